>>> hw/rtl/wav_pcm_stream_parser_assert.svh
// Assertion macros used by the parser top level.
`ifndef WAV_PCM_STREAM_PARSER_ASSERT_SVH
`define WAV_PCM_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define WPSP_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define WPSP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/wpsp_pkg.sv
`default_nettype none

package wpsp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_INFO    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Error codes
  localparam logic [3:0] ERR_HDR_SHORT   = 4'd0;
  localparam logic [3:0] ERR_FMT_SIZE    = 4'd1;
  localparam logic [3:0] ERR_EXT_SHORT   = 4'd2;
  localparam logic [3:0] ERR_NOT_PCM     = 4'd3;
  localparam logic [3:0] ERR_BAD_IDS     = 4'd4;
  localparam logic [3:0] ERR_UNSUPPORTED = 4'd5;
  localparam logic [3:0] ERR_ALIGN       = 4'd6;
  localparam logic [3:0] ERR_CHUNK_SHORT = 4'd7;
  localparam logic [3:0] ERR_CHUNK_OVER  = 4'd8;
  localparam logic [3:0] ERR_NOT_DATA    = 4'd9;
  localparam logic [3:0] ERR_DATA_OVER   = 4'd10;

  // Header layout
  localparam int unsigned HdrBytes   = 36;
  localparam int unsigned ExtBytes   = 38;
  localparam int unsigned FmtSizePcm = 16;
  localparam int unsigned FmtSizeExt = 18;
  localparam int unsigned ChunkHdr   = 8;

  // Four-character chunk tags
  localparam logic [7:0] TAG_RIFF [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
  localparam logic [7:0] TAG_WAVE [4] = '{8'h57, 8'h41, 8'h56, 8'h45};
  localparam logic [7:0] TAG_FMT  [4] = '{8'h66, 8'h6d, 8'h74, 8'h20};
  localparam logic [7:0] TAG_DATA [4] = '{8'h64, 8'h61, 8'h74, 8'h61};

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [1:0]  format_code;
    logic [31:0] sample_rate;
    logic [31:0] frame_count;
    logic [3:0]  error_code;
    logic        last;
  } wpsp_res_t;

  // Parser status seen by the top level
  typedef struct packed {
    logic res_valid;
    logic done;
  } wpsp_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/wpsp_in_reg.sv
`default_nettype none

module wpsp_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       adv_i,
  output logic            s1_valid_o,
  output logic [7:0]      s1_byte_o
);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       accept;

  // Stall only when the held byte cannot move on
  assign in_stall_o = s1_valid_q & ~adv_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (adv_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Capture the byte of each input transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q <= in_byte_i;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_byte_o  = s1_byte_q;

endmodule

`default_nettype wire

>>> hw/rtl/wpsp_parse.sv
`default_nettype none

module wpsp_parse (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  output wpsp_pkg::wpsp_res_t  res_o,
  output wpsp_pkg::wpsp_stat_t stat_o
);

  import wpsp_pkg::*;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_CBSIZE  = 3'd1;
  localparam logic [2:0] PH_SKIP    = 3'd2;
  localparam logic [2:0] PH_CHID    = 3'd3;
  localparam logic [2:0] PH_CHSIZE  = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  localparam logic [5:0] HDR_LAST = 6'(HdrBytes - 1);

  logic [2:0]  phase_q, phase_d;
  logic [5:0]  hdr_pos_q, hdr_pos_d;
  logic [31:0] left_q, left_d;
  logic [1:0]  fsh_q, fsh_d;
  logic [31:0] fmt_size_q, fmt_size_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] align_q, align_d;
  logic [15:0] bits_q, bits_d;
  logic [3:0]  ok_q, ok_d;
  logic [31:0] skip_q, skip_d;
  logic [31:0] pay_q, pay_d;
  logic        second_q, second_d;

  logic        res_valid;
  wpsp_res_t   res;
  logic        err_hit;
  logic [3:0]  err_code;
  logic [3:0]  ok_base;

  // Header checks, evaluated on the last header byte
  logic [15:0] bits_full;
  logic [15:0] exp_align;
  logic        chan_ok, bits_ok;
  logic        hdr_bad;
  logic [3:0]  hdr_code;

  // Chunk size and payload length math
  logic [31:0] size_full;
  logic [31:0] frames;
  logic [31:0] pay_len;
  logic [32:0] cb_need;
  logic [32:0] size_need;
  logic [32:0] left_ext;

  assign bits_full = {byte_i, bits_q[7:0]};
  assign chan_ok   = (chan_q == 16'd1) || (chan_q == 16'd2);
  assign bits_ok   = (bits_full == 16'd8) || (bits_full == 16'd16);

  always_comb begin
    case ({chan_q == 16'd2, bits_full == 16'd16})
      2'b00:   exp_align = 16'd1;
      2'b01:   exp_align = 16'd2;
      2'b10:   exp_align = 16'd2;
      default: exp_align = 16'd4;
    endcase
  end

  always_comb begin
    hdr_bad  = 1'b1;
    hdr_code = ERR_NOT_PCM;
    if (!ok_q[3]) begin
      hdr_code = ERR_NOT_PCM;
    end else if (ok_q[2:0] != 3'b111) begin
      hdr_code = ERR_BAD_IDS;
    end else if (!chan_ok || !bits_ok) begin
      hdr_code = ERR_UNSUPPORTED;
    end else if (align_q != exp_align) begin
      hdr_code = ERR_ALIGN;
    end else begin
      hdr_bad = 1'b0;
    end
  end

  // Block align is 1, 2 or 4 once the header passed: divide by shifting
  assign size_full = {byte_i, skip_q[23:0]};
  always_comb begin
    case (align_q[2:0])
      3'd4: begin
        frames  = {2'b00, size_full[31:2]};
        pay_len = {size_full[31:2], 2'b00};
      end
      3'd2: begin
        frames  = {1'b0, size_full[31:1]};
        pay_len = {size_full[31:1], 1'b0};
      end
      default: begin
        frames  = size_full;
        pay_len = size_full;
      end
    endcase
  end

  // left_q counts bytes not yet taken, so "past end" compares against it
  assign left_ext  = {1'b0, left_q};
  assign cb_need   = {17'd0, byte_i, skip_q[7:0]} + 33'(ChunkHdr);
  assign size_need = {1'b0, size_full} + 33'(ChunkHdr);
  assign ok_base   = (hdr_pos_q == 6'd0) ? 4'hf : ok_q;

  always_comb begin
    phase_d    = phase_q;
    hdr_pos_d  = hdr_pos_q;
    left_d     = left_q;
    fsh_d      = fsh_q;
    fmt_size_d = fmt_size_q;
    chan_d     = chan_q;
    rate_d     = rate_q;
    align_d    = align_q;
    bits_d     = bits_q;
    ok_d       = ok_q;
    skip_d     = skip_q;
    pay_d      = pay_q;
    second_d   = second_q;
    res_valid  = 1'b0;
    res        = '0;
    err_hit    = 1'b0;
    err_code   = ERR_HDR_SHORT;

    if (cfg_we_i) begin
      // New file: clear the parse and load its length
      phase_d    = PH_HEADER;
      hdr_pos_d  = '0;
      left_d     = cfg_wdata_i;
      fsh_d      = '0;
      fmt_size_d = '0;
      chan_d     = '0;
      rate_d     = '0;
      align_d    = '0;
      bits_d     = '0;
      ok_d       = '0;
      skip_d     = '0;
      pay_d      = '0;
      second_d   = 1'b0;
    end else if (step_i && (phase_q != PH_DONE) && (left_q != 32'd0)) begin
      left_d = left_q - 32'd1;
      case (phase_q)
        PH_HEADER: begin
          hdr_pos_d = hdr_pos_q + 6'd1;
          ok_d      = ok_base;
          if ((hdr_pos_q == 6'd0) && (left_q < 32'(HdrBytes))) begin
            err_hit  = 1'b1;
            err_code = ERR_HDR_SHORT;
          end else begin
            // Collect header fields, little-endian
            if (hdr_pos_q inside {[6'd0:6'd3]}) begin
              if (byte_i != TAG_RIFF[hdr_pos_q[1:0]]) ok_d[0] = 1'b0;
            end else if (hdr_pos_q inside {[6'd8:6'd11]}) begin
              if (byte_i != TAG_WAVE[hdr_pos_q[1:0]]) ok_d[1] = 1'b0;
            end else if (hdr_pos_q inside {[6'd12:6'd15]}) begin
              if (byte_i != TAG_FMT[hdr_pos_q[1:0]]) ok_d[2] = 1'b0;
            end else if (hdr_pos_q inside {[6'd16:6'd19]}) begin
              fmt_size_d[{hdr_pos_q[1:0], 3'b000} +: 8] = byte_i;
            end else if (hdr_pos_q == 6'd20) begin
              if (byte_i != 8'd1) ok_d[3] = 1'b0;
            end else if (hdr_pos_q == 6'd21) begin
              if (byte_i != 8'd0) ok_d[3] = 1'b0;
            end else if (hdr_pos_q inside {[6'd22:6'd23]}) begin
              chan_d[{hdr_pos_q[0], 3'b000} +: 8] = byte_i;
            end else if (hdr_pos_q inside {[6'd24:6'd27]}) begin
              rate_d[{hdr_pos_q[1:0], 3'b000} +: 8] = byte_i;
            end else if (hdr_pos_q inside {[6'd32:6'd33]}) begin
              align_d[{hdr_pos_q[0], 3'b000} +: 8] = byte_i;
            end else if (hdr_pos_q inside {[6'd34:6'd35]}) begin
              bits_d[{hdr_pos_q[0], 3'b000} +: 8] = byte_i;
            end

            // Judge the header on its last byte
            if (hdr_pos_q == HDR_LAST) begin
              if (fmt_size_q == 32'(FmtSizeExt)) begin
                if (left_q < 32'(ExtBytes - HdrBytes + 1)) begin
                  err_hit  = 1'b1;
                  err_code = ERR_EXT_SHORT;
                end else if (hdr_bad) begin
                  err_hit  = 1'b1;
                  err_code = hdr_code;
                end else begin
                  phase_d = PH_CBSIZE;
                  fsh_d   = '0;
                  skip_d  = '0;
                end
              end else if (fmt_size_q != 32'(FmtSizePcm)) begin
                err_hit  = 1'b1;
                err_code = ERR_FMT_SIZE;
              end else if (hdr_bad) begin
                err_hit  = 1'b1;
                err_code = hdr_code;
              end else if (left_q <= 32'(ChunkHdr)) begin
                err_hit  = 1'b1;
                err_code = ERR_CHUNK_SHORT;
              end else begin
                phase_d = PH_CHID;
                fsh_d   = '0;
                ok_d    = 4'b0001;
                skip_d  = '0;
              end
            end
          end
        end

        PH_CBSIZE: begin
          // Extension length, then skip that many bytes
          skip_d[{fsh_q, 3'b000} +: 8] = byte_i;
          fsh_d = fsh_q + 2'd1;
          if (fsh_q == 2'd1) begin
            if (cb_need >= left_ext) begin
              err_hit  = 1'b1;
              err_code = ERR_CHUNK_SHORT;
            end else if ({byte_i, skip_q[7:0]} == 16'd0) begin
              phase_d = PH_CHID;
              fsh_d   = '0;
              ok_d    = 4'b0001;
              skip_d  = '0;
            end else begin
              phase_d = PH_SKIP;
            end
          end
        end

        PH_SKIP: begin
          skip_d = skip_q - 32'd1;
          if (skip_q == 32'd1) begin
            phase_d = PH_CHID;
            fsh_d   = '0;
            ok_d    = 4'b0001;
            skip_d  = '0;
          end
        end

        PH_CHID: begin
          if (byte_i != TAG_DATA[fsh_q]) ok_d[0] = 1'b0;
          fsh_d = fsh_q + 2'd1;
          if (fsh_q == 2'd3) begin
            phase_d = PH_CHSIZE;
          end
        end

        PH_CHSIZE: begin
          skip_d[{fsh_q, 3'b000} +: 8] = byte_i;
          fsh_d = fsh_q + 2'd1;
          if (fsh_q == 2'd3) begin
            if (!ok_q[0]) begin
              // Other chunk: allow one, then skip it
              if (second_q) begin
                err_hit  = 1'b1;
                err_code = ERR_NOT_DATA;
              end else if (size_full >= left_q) begin
                err_hit  = 1'b1;
                err_code = ERR_CHUNK_OVER;
              end else if (size_need >= left_ext) begin
                err_hit  = 1'b1;
                err_code = ERR_CHUNK_SHORT;
              end else begin
                second_d = 1'b1;
                if (size_full == 32'd0) begin
                  phase_d = PH_CHID;
                  fsh_d   = '0;
                  ok_d    = 4'b0001;
                  skip_d  = '0;
                end else begin
                  phase_d = PH_SKIP;
                end
              end
            end else if (pay_len >= left_q) begin
              err_hit  = 1'b1;
              err_code = ERR_DATA_OVER;
            end else begin
              // Data chunk: report format, then stream whole frames
              pay_d           = pay_len;
              res_valid       = 1'b1;
              res.kind        = KIND_INFO;
              res.format_code = {chan_q == 16'd2, bits_q == 16'd16};
              res.sample_rate = rate_q;
              res.frame_count = frames;
              res.last        = (pay_len == 32'd0);
              phase_d         = (pay_len == 32'd0) ? PH_DONE : PH_PAYLOAD;
            end
          end
        end

        PH_PAYLOAD: begin
          pay_d        = pay_q - 32'd1;
          res_valid    = 1'b1;
          res.kind     = KIND_PAYLOAD;
          res.out_byte = byte_i;
          if (pay_q == 32'd1) begin
            res.last = 1'b1;
            phase_d  = PH_DONE;
          end
        end

        default: begin
          phase_d = PH_DONE;
        end
      endcase

      // First failed check ends the file
      if (err_hit) begin
        res_valid      = 1'b1;
        res            = '0;
        res.kind       = KIND_ERROR;
        res.error_code = err_code;
        res.last       = 1'b1;
        phase_d        = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      hdr_pos_q  <= '0;
      left_q     <= '0;
      fsh_q      <= '0;
      fmt_size_q <= '0;
      chan_q     <= '0;
      rate_q     <= '0;
      align_q    <= '0;
      bits_q     <= '0;
      ok_q       <= '0;
      skip_q     <= '0;
      pay_q      <= '0;
      second_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      hdr_pos_q  <= hdr_pos_d;
      left_q     <= left_d;
      fsh_q      <= fsh_d;
      fmt_size_q <= fmt_size_d;
      chan_q     <= chan_d;
      rate_q     <= rate_d;
      align_q    <= align_d;
      bits_q     <= bits_d;
      ok_q       <= ok_d;
      skip_q     <= skip_d;
      pay_q      <= pay_d;
      second_q   <= second_d;
    end
  end

  assign res_o            = res;
  assign stat_o.res_valid = res_valid;
  assign stat_o.done      = (phase_q == PH_DONE);

endmodule

`default_nettype wire

>>> hw/rtl/wpsp_out_reg.sv
`default_nettype none

module wpsp_out_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wpsp_pkg::wpsp_res_t      res_i,
  output logic                     free_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output wpsp_pkg::wpsp_res_t      res_o
);

  import wpsp_pkg::*;

  logic      out_valid_q, out_valid_d;
  wpsp_res_t res_q;

  // Slot can take a result when empty or emptied this cycle
  assign free_o = ~out_valid_q | ~out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_i) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result until its transaction completes
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> hw/rtl/wav_pcm_stream_parser.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------
// in       | in_valid_i/in_stall_o | in_byte_i
// out      | out_valid_o/out_stall_i | kind_o, out_byte_o, format_code_o,
//          |                       | sample_rate_o, frame_count_o,
//          |                       | error_code_o, last_o
// cfg      | cfg_we_i              | cfg_wdata_i (file length)
//
// One byte per cycle sustained while the output is not stalled; a byte sits in
// the input register, is parsed by one pass of compare/update logic and its
// result lands in the output register.
// Reset clears all parse state at once; no clearing pass is needed.
// A stalled output register holds the input register, which then stalls in.
`default_nettype none

module wav_pcm_stream_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       out_byte_o,
  output logic [1:0]       format_code_o,
  output logic [31:0]      sample_rate_o,
  output logic [31:0]      frame_count_o,
  output logic [3:0]       error_code_o,
  output logic             last_o
);

  import wpsp_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       out_free;
  logic       adv;
  wpsp_res_t  res;
  wpsp_res_t  res_out;
  wpsp_stat_t stat;

  // Move the held byte whenever the output slot can take its result
  assign adv = s1_valid & out_free;

  wpsp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .adv_i      (adv),
    .s1_valid_o (s1_valid),
    .s1_byte_o  (s1_byte)
  );

  wpsp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (adv),
    .byte_i      (s1_byte),
    .res_o       (res),
    .stat_o      (stat)
  );

  wpsp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (stat.res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign kind_o        = res_out.kind;
  assign out_byte_o    = res_out.out_byte;
  assign format_code_o = res_out.format_code;
  assign sample_rate_o = res_out.sample_rate;
  assign frame_count_o = res_out.frame_count;
  assign error_code_o  = res_out.error_code;
  assign last_o        = res_out.last;

`include "wav_pcm_stream_parser_assert.svh"

  `WPSP_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_o, s1_valid && out_valid_o && out_stall_i, "input stalled without a blocked output")
  `WPSP_ASSERT_NEXT(a_in_captured, clk_i, rst_ni, in_valid_i && !in_stall_o, s1_valid, "input transaction not captured")
  `WPSP_ASSERT_NOW(a_done_silent, clk_i, rst_ni, stat.done && !cfg_we_i, !stat.res_valid, "result produced after end of file")
  `WPSP_ASSERT_NOW(a_error_last, clk_i, rst_ni, out_valid_o && (kind_o == KIND_ERROR), last_o && (out_byte_o == 8'd0), "error result without last mark")

endmodule

`default_nettype wire

>>> tb/wav_pcm_stream_parser_tb.sv
`timescale 1ns / 1ps

module wav_pcm_stream_parser_tb;
  import wpsp_pkg::*;

  localparam int unsigned WaveFormatPcm = 1;
  localparam int unsigned InputItems    = 1250;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned QuietLimit    = 1000;

  typedef enum int unsigned {
    SC_GOOD, SC_SHORT_HDR, SC_FMT_SIZE, SC_EXT_SHORT, SC_NOT_PCM, SC_BAD_IDS,
    SC_UNSUPPORTED, SC_ALIGN, SC_CHUNK_SHORT, SC_CHUNK_OVER, SC_NOT_DATA,
    SC_DATA_OVER, SC_ZERO_FRAMES, SC_OPEN_LENGTH, SC_NO_LENGTH, SC_NOISE
  } scenario_e;

  // Track parser state per byte and hold the results it should produce
  class wav_parse_scoreboard;
    typedef enum logic [2:0] {
      PH_HEADER, PH_CBSIZE, PH_SKIP, PH_CHID, PH_CHSIZE, PH_PAYLOAD, PH_DONE
    } phase_e;

    logic [31:0] file_len;
    logic [31:0] byte_pos;
    phase_e      phase;
    int unsigned shift;
    logic [31:0] fmt_size;
    logic [31:0] rate;
    logic [31:0] chunk_len;
    logic [31:0] pay_left;
    logic [15:0] chans;
    logic [15:0] align;
    logic [15:0] sample_bits;
    logic [3:0]  id_ok;
    bit          second_chunk;

    wpsp_res_t   parsed_results[$];
    int unsigned bytes_parsed;
    int unsigned mismatches;
    int unsigned n_info;
    int unsigned n_payload;
    int unsigned n_error;

    function new();
      file_len     = '0;
      bytes_parsed = 0;
      mismatches   = 0;
      n_info       = 0;
      n_payload    = 0;
      n_error      = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      byte_pos     = '0;
      phase        = PH_HEADER;
      shift        = 0;
      fmt_size     = '0;
      rate         = '0;
      chunk_len    = '0;
      pay_left     = '0;
      chans        = '0;
      align        = '0;
      sample_bits  = '0;
      id_ok        = '0;
      second_chunk = 1'b0;
    endfunction

    // A length write starts a new file
    function void load_length(logic [31:0] len);
      file_len = len;
      clear_parse();
    endfunction

    function void push_error(logic [3:0] code);
      wpsp_res_t r;
      r            = '0;
      r.kind       = KIND_ERROR;
      r.error_code = code;
      r.last       = 1'b1;
      parsed_results.push_back(r);
      phase = PH_DONE;
    endfunction

    function void open_chunk();
      phase     = PH_CHID;
      shift     = 0;
      id_ok     = 4'b0001;
      chunk_len = '0;
    endfunction

    // Header content checks in priority order; returns 1 on the first fault
    function bit header_fault(output logic [3:0] code);
      code = '0;
      if (!id_ok[3]) code = ERR_NOT_PCM;
      else if (id_ok[2:0] != 3'b111) code = ERR_BAD_IDS;
      else if ((chans != 16'd1 && chans != 16'd2) ||
               (sample_bits != 16'd8 && sample_bits != 16'd16)) code = ERR_UNSUPPORTED;
      else if (32'(align) != 32'(chans) * 32'(sample_bits) / 32'd8) code = ERR_ALIGN;
      else return 1'b0;
      return 1'b1;
    endfunction

    // Advance the parse by one accepted byte
    function void note_byte(logic [7:0] b);
      longint unsigned done;
      longint unsigned len;
      logic [31:0]     p;
      logic [31:0]     frames;
      logic [31:0]     pay;
      logic [3:0]      code;
      wpsp_res_t       r;
      if (phase == PH_DONE || byte_pos >= file_len) return;
      p        = byte_pos;
      byte_pos = p + 1;
      done     = 64'(p) + 1;
      len      = 64'(file_len);
      bytes_parsed++;
      case (phase)
        PH_HEADER: begin
          if (p == 0 && len < HdrBytes) begin
            push_error(ERR_HDR_SHORT);
            return;
          end
          if (p == 0) id_ok = 4'hF;
          if (p < 4) begin
            if (b != TAG_RIFF[p]) id_ok[0] = 1'b0;
          end else if (p >= 8 && p < 12) begin
            if (b != TAG_WAVE[p - 8]) id_ok[1] = 1'b0;
          end else if (p >= 12 && p < 16) begin
            if (b != TAG_FMT[p - 12]) id_ok[2] = 1'b0;
          end else if (p >= 16 && p < 20) begin
            fmt_size |= 32'(b) << (8 * (p - 16));
          end else if (p == 20) begin
            if (b != 8'(WaveFormatPcm)) id_ok[3] = 1'b0;
          end else if (p == 21) begin
            if (b != 8'd0) id_ok[3] = 1'b0;
          end else if (p >= 22 && p < 24) begin
            chans |= 16'(b) << (8 * (p - 22));
          end else if (p >= 24 && p < 28) begin
            rate |= 32'(b) << (8 * (p - 24));
          end else if (p >= 32 && p < 34) begin
            align |= 16'(b) << (8 * (p - 32));
          end else if (p >= 34 && p < 36) begin
            sample_bits |= 16'(b) << (8 * (p - 34));
          end
          if (p != HdrBytes - 1) return;
          if (fmt_size == FmtSizeExt) begin
            if (len < ExtBytes) push_error(ERR_EXT_SHORT);
            else if (header_fault(code)) push_error(code);
            else begin
              phase     = PH_CBSIZE;
              shift     = 0;
              chunk_len = '0;
            end
          end else if (fmt_size != FmtSizePcm) begin
            push_error(ERR_FMT_SIZE);
          end else if (header_fault(code)) begin
            push_error(code);
          end else if (done + ChunkHdr > len) begin
            push_error(ERR_CHUNK_SHORT);
          end else begin
            open_chunk();
          end
        end
        PH_CBSIZE: begin
          chunk_len |= 32'(b) << shift;
          shift += 8;
          if (shift < 16) return;
          if (done + 64'(chunk_len) + ChunkHdr > len) push_error(ERR_CHUNK_SHORT);
          else if (chunk_len == 0) open_chunk();
          else phase = PH_SKIP;
        end
        PH_SKIP: begin
          chunk_len--;
          if (chunk_len == 0) open_chunk();
        end
        PH_CHID: begin
          if (b != TAG_DATA[(shift >> 3) & 3]) id_ok[0] = 1'b0;
          shift += 8;
          if (shift >= 32) begin
            phase = PH_CHSIZE;
            shift = 0;
          end
        end
        PH_CHSIZE: begin
          chunk_len |= 32'(b) << shift;
          shift += 8;
          if (shift < 32) return;
          if (!id_ok[0]) begin
            // Skip one foreign chunk; a second one is fatal
            if (second_chunk) push_error(ERR_NOT_DATA);
            else if (done + 64'(chunk_len) > len) push_error(ERR_CHUNK_OVER);
            else if (done + 64'(chunk_len) + ChunkHdr > len) push_error(ERR_CHUNK_SHORT);
            else begin
              second_chunk = 1'b1;
              if (chunk_len == 0) open_chunk();
              else phase = PH_SKIP;
            end
          end else begin
            frames = (align != 0) ? chunk_len / 32'(align) : '0;
            pay    = frames * 32'(align);
            if (done + 64'(pay) > len) begin
              push_error(ERR_DATA_OVER);
            end else begin
              pay_left      = pay;
              r             = '0;
              r.kind        = KIND_INFO;
              r.format_code = 2'(((32'(chans) - 1) << 1) +
                                 (sample_bits == 16'd16 ? 32'd1 : 32'd0));
              r.sample_rate = rate;
              r.frame_count = frames;
              r.last        = (pay == 0);
              parsed_results.push_back(r);
              phase = (pay != 0) ? PH_PAYLOAD : PH_DONE;
            end
          end
        end
        PH_PAYLOAD: begin
          pay_left--;
          r          = '0;
          r.kind     = KIND_PAYLOAD;
          r.out_byte = b;
          if (pay_left == 0) begin
            r.last = 1'b1;
            phase  = PH_DONE;
          end
          parsed_results.push_back(r);
        end
        default: phase = PH_DONE;
      endcase
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      $display("%0t: %s", $time, msg);
    endfunction

    function void field_diff(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v)
        note_mismatch($sformatf("%s expected %0h actual %0h", name, want_v, got_v));
    endfunction

    // Compare one output transaction against the oldest prediction
    function void check_result(wpsp_res_t got);
      wpsp_res_t want;
      if (parsed_results.size() == 0) begin
        note_mismatch($sformatf("result with none expected: kind %0h byte %0h code %0h",
                                got.kind, got.out_byte, got.error_code));
        return;
      end
      want = parsed_results.pop_front();
      case (want.kind)
        KIND_INFO:    n_info++;
        KIND_PAYLOAD: n_payload++;
        default:      n_error++;
      endcase
      field_diff("kind", want.kind, got.kind);
      field_diff("out_byte", want.out_byte, got.out_byte);
      field_diff("format_code", want.format_code, got.format_code);
      field_diff("sample_rate", want.sample_rate, got.sample_rate);
      field_diff("frame_count", want.frame_count, got.frame_count);
      field_diff("error_code", want.error_code, got.error_code);
      field_diff("last", want.last, got.last);
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  out_byte_o;
  logic [1:0]  format_code_o;
  logic [31:0] sample_rate_o;
  logic [31:0] frame_count_o;
  logic [3:0]  error_code_o;
  logic        last_o;

  wav_parse_scoreboard sb = new();
  logic [7:0]  file_q[$];
  logic [31:0] file_len;
  bit          calm = 1'b0;
  int unsigned files_run = 0;
  int unsigned bytes_sent = 0;

  wav_pcm_stream_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .out_byte_o    (out_byte_o),
    .format_code_o (format_code_o),
    .sample_rate_o (sample_rate_o),
    .frame_count_o (frame_count_o),
    .error_code_o  (error_code_o),
    .last_o        (last_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Stall the result side at random, except during calm stretches
  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 22);
  end

  // Sample every transaction at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.load_length(cfg_wdata_i);
      if (in_valid_i && !in_stall_o) sb.note_byte(in_byte_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result({kind_o, out_byte_o, format_code_o, sample_rate_o,
                         frame_count_o, error_code_o, last_o});
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) ||
          (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, QuietLimit);
    $display("[wav_pcm_stream_parser] ERROR");
    $finish;
  end

  function automatic void put_le(input logic [31:0] value, input int unsigned n);
    for (int i = 0; i < n; i++) file_q.push_back(8'(value >> (8 * i)));
  endfunction

  function automatic void put_tag(input logic [7:0] tag [4]);
    for (int i = 0; i < 4; i++) file_q.push_back(tag[i]);
  endfunction

  function automatic void put_random(input int unsigned n);
    repeat (n) file_q.push_back(8'($urandom));
  endfunction

  // Append a chunk whose ID never reads as data
  function automatic void put_other_chunk(input int unsigned n);
    logic [7:0] id0;
    id0 = 8'($urandom);
    if (id0 == TAG_DATA[0]) id0 ^= 8'h01;
    file_q.push_back(id0);
    put_random(3);
    put_le(n, 4);
    put_random(n);
  endfunction

  // Build one file: a well-formed stream, then the damage the scenario calls for
  function automatic void build_file(input scenario_e sc);
    int unsigned ch, width, blk, cb, other_n, data_n, hdr_end, other_at, data_at, pay;
    int unsigned idx, v;
    logic [31:0] rate;
    bit          ext_fmt;
    file_q.delete();
    ch    = $urandom_range(1, 2);
    width = $urandom_range(0, 1) ? 16 : 8;
    blk   = ch * width / 8;
    case ($urandom_range(0, 3))
      0:       rate = 32'd8000;
      1:       rate = 32'd44100;
      2:       rate = 32'd48000;
      default: rate = $urandom;
    endcase
    ext_fmt = (sc == SC_EXT_SHORT) || ($urandom_range(0, 3) == 0);
    if (sc == SC_ZERO_FRAMES) data_n = $urandom_range(0, blk - 1);
    else if (sc == SC_DATA_OVER) data_n = $urandom_range(blk, 40);
    else if ($urandom_range(0, 9) == 0) data_n = $urandom_range(41, 160);
    else data_n = $urandom_range(0, 40);

    put_tag(TAG_RIFF);
    put_le($urandom, 4);
    put_tag(TAG_WAVE);
    put_tag(TAG_FMT);
    put_le(ext_fmt ? FmtSizeExt : FmtSizePcm, 4);
    put_le(WaveFormatPcm, 2);
    put_le(ch, 2);
    put_le(rate, 4);
    put_le(rate * blk, 4);
    put_le(blk, 2);
    put_le(width, 2);
    if (ext_fmt) begin
      cb = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      put_le(cb, 2);
      put_random(cb);
    end
    hdr_end  = file_q.size();
    other_n  = (sc == SC_CHUNK_OVER) ? $urandom_range(1, 8) : $urandom_range(0, 8);
    other_at = hdr_end + ChunkHdr;
    if (sc inside {SC_CHUNK_OVER, SC_NOT_DATA} || $urandom_range(0, 2) == 0)
      put_other_chunk(other_n);
    if (sc == SC_NOT_DATA) put_other_chunk($urandom_range(0, 4));
    put_tag(TAG_DATA);
    put_le((sc == SC_OPEN_LENGTH) ? $urandom : data_n, 4);
    data_at = file_q.size();
    put_random((sc == SC_OPEN_LENGTH) ? 24 : data_n);
    file_len = file_q.size();
    // Trailing bytes past the stated length
    put_random($urandom_range(0, 4));
    pay = (data_n / blk) * blk;

    case (sc)
      SC_SHORT_HDR: file_len = $urandom_range(1, HdrBytes - 1);
      SC_FMT_SIZE: begin
        if ($urandom_range(0, 1)) begin
          idx = $urandom_range(0, 6);
          if (idx >= 1) idx++;
          file_q[16] = 8'(FmtSizePcm) ^ (8'h01 << idx);
        end else begin
          file_q[17 + $urandom_range(0, 2)] = 8'($urandom_range(1, 255));
        end
      end
      SC_EXT_SHORT: file_len = $urandom_range(HdrBytes, ExtBytes - 1);
      SC_NOT_PCM:   file_q[20 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      SC_BAD_IDS: begin
        idx = $urandom_range(0, 11);
        if (idx >= 4) idx += 4;
        file_q[idx] ^= 8'($urandom_range(1, 255));
      end
      SC_UNSUPPORTED: begin
        case ($urandom_range(0, 3))
          0: file_q[22] = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(3, 255));
          1: file_q[23] = 8'($urandom_range(1, 255));
          2: begin
            v = $urandom_range(0, 255);
            if (v == 8 || v == 16) v = 24;
            file_q[34] = 8'(v);
          end
          default: file_q[35] = 8'($urandom_range(1, 255));
        endcase
      end
      SC_ALIGN:       file_q[32] += 8'($urandom_range(1, 3));
      SC_CHUNK_SHORT: file_len = hdr_end + $urandom_range(0, ChunkHdr - 1);
      SC_CHUNK_OVER:  file_len = other_at + $urandom_range(0, other_n - 1);
      SC_DATA_OVER: begin
        if ($urandom_range(0, 1)) file_len = data_at + $urandom_range(0, pay - 1);
        else file_q[data_at - 1] = 8'($urandom_range(16, 255));
      end
      SC_OPEN_LENGTH: file_len = '1;
      SC_NO_LENGTH:   file_len = '0;
      SC_NOISE: begin
        file_q.delete();
        put_random($urandom_range(1, 48));
        file_len = $urandom_range(0, 1) ? 32'($urandom_range(0, 60)) : $urandom;
      end
      SC_GOOD: begin
        // Now and then damage one byte anywhere in the file
        if ($urandom_range(0, 4) == 0)
          file_q[$urandom_range(0, file_q.size() - 1)] ^= 8'($urandom_range(1, 255));
      end
      default: ;
    endcase
  endfunction

  // Present one byte and hold it until the transaction completes
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < 22) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Wait for every predicted result, then let the pipeline empty
  task automatic wait_drained();
    while (sb.parsed_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic run_file(input scenario_e sc);
    build_file(sc);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= file_len;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    foreach (file_q[i]) send_byte(file_q[i]);
    in_valid_i <= 1'b0;
    wait_drained();
    files_run++;
  endtask

  initial begin : stimulus
    scenario_e sc;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Length is zero out of reset: these bytes must be dropped
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(TAG_RIFF[0]);
    in_valid_i <= 1'b0;
    wait_drained();

    // Directed pass: one file per scenario, with a calm stretch in the middle
    sc = sc.first();
    do begin
      calm = (sc >= SC_ALIGN) && (sc <= SC_NOT_DATA);
      run_file(sc);
      sc = sc.next();
    end while (sc != sc.first());
    calm = 1'b0;

    // Random files, mostly well formed, until the byte budget is spent
    while (bytes_sent < InputItems) begin
      if ($urandom_range(0, 99) < 55) sc = SC_GOOD;
      else sc = scenario_e'($urandom_range(0, sc.num() - 1));
      run_file(sc);
    end

    $display("Ran %0d files, %0d bytes sent, %0d parsed; checked %0d info, %0d payload, %0d error results.",
             files_run, bytes_sent, sb.bytes_parsed, sb.n_info, sb.n_payload, sb.n_error);
    $display("Field mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[wav_pcm_stream_parser] OK");
    end else begin
      $display("[wav_pcm_stream_parser] ERROR");
    end
    $finish;
  end

endmodule
